/* hw/rtl/dpp_pkg.sv */
package dpp_pkg;

   typedef logic [2:0] csr_idx_type;

   localparam csr_idx_type CSR_DEPTH_SCALE = 3'd0;
   localparam csr_idx_type CSR_INV_FOCAL_X = 3'd1;
   localparam csr_idx_type CSR_INV_FOCAL_Y = 3'd2;
   localparam csr_idx_type CSR_CENTER_X    = 3'd3;
   localparam csr_idx_type CSR_CENTER_Y    = 3'd4;
   localparam csr_idx_type CSR_XFORM_ROW_X = 3'd5;
   localparam csr_idx_type CSR_XFORM_ROW_Y = 3'd6;
   localparam csr_idx_type CSR_XFORM_ROW_Z = 3'd7;

   localparam logic [23:0] RST_DEPTH_SCALE = 24'd16777;
   localparam logic [23:0] RST_INV_FOCAL   = 24'd31957;
   localparam logic [15:0] RST_CENTER_X    = 16'd5112;
   localparam logic [15:0] RST_CENTER_Y    = 16'd3832;
   localparam logic [63:0] RST_XFORM_ROW_X = 64'h4000_0000_0000_0000;
   localparam logic [63:0] RST_XFORM_ROW_Y = 64'h0000_4000_0000_0000;
   localparam logic [63:0] RST_XFORM_ROW_Z = 64'h0000_0000_4000_0000;

   // pipeline depth, input register to output register
   localparam int NumStages = 8;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

endpackage

/* hw/rtl/depth_pixel_to_point.sv */
// channel | dir | handshake                 | payload
// req     | in  | req_valid / req_stall     | pixel_col, pixel_row, depth_raw, blue/green/red
// rsp     | out | rsp_valid / rsp_stall     | point_x/y/z (Q15.16), blue/green/red
// csr     | in  | csr_valid / csr_ready     | csr_index, csr_wdata
//
// one beat per clock sustained while rsp is not stalled; a pixel goes from req to rsp
// through the chain of multipliers (depth scale, focal scale, depth times ray, 3x3 transform),
// each followed by its own rounding or summing stage.
// reset (synchronous) empties the pipeline and loads the default intrinsics and transform.
// a stalled rsp holds the output register; stages behind it keep filling bubbles,
// so req_stall rises only once every stage holds a beat.
module depth_pixel_to_point
   import dpp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [11:0]        req_pixel_col,
   input  logic [11:0]        req_pixel_row,
   input  logic [15:0]        req_depth_raw,
   input  logic [7:0]         req_blue_in,
   input  logic [7:0]         req_green_in,
   input  logic [7:0]         req_red_in,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic signed [31:0] rsp_point_z,
   output logic [7:0]         rsp_blue_out,
   output logic [7:0]         rsp_green_out,
   output logic [7:0]         rsp_red_out,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  csr_idx_type        csr_index,
   input  logic [63:0]        csr_wdata
);

   // configuration registers
   logic [23:0] depth_scale_ff, inv_focal_x_ff, inv_focal_y_ff;
   logic [15:0] center_x_ff, center_y_ff;
   logic [63:0] xform_ff [3];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_scale_ff <= RST_DEPTH_SCALE;
         inv_focal_x_ff <= RST_INV_FOCAL;
         inv_focal_y_ff <= RST_INV_FOCAL;
         center_x_ff    <= RST_CENTER_X;
         center_y_ff    <= RST_CENTER_Y;
         xform_ff[0]    <= RST_XFORM_ROW_X;
         xform_ff[1]    <= RST_XFORM_ROW_Y;
         xform_ff[2]    <= RST_XFORM_ROW_Z;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEPTH_SCALE: depth_scale_ff <= csr_wdata[23:0];
            CSR_INV_FOCAL_X: inv_focal_x_ff <= csr_wdata[23:0];
            CSR_INV_FOCAL_Y: inv_focal_y_ff <= csr_wdata[23:0];
            CSR_CENTER_X:    center_x_ff    <= csr_wdata[15:0];
            CSR_CENTER_Y:    center_y_ff    <= csr_wdata[15:0];
            CSR_XFORM_ROW_X: xform_ff[0]    <= csr_wdata;
            CSR_XFORM_ROW_Y: xform_ff[1]    <= csr_wdata;
            CSR_XFORM_ROW_Z: xform_ff[2]    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // flow control: a stage loads when it is empty or the one ahead moves
   logic [NumStages:1] vld_ff, vld_in, en;

   always_comb begin
      en[NumStages] = !vld_ff[NumStages] || !rsp_stall;
      for (int k = NumStages - 1; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign vld_in    = {vld_ff[NumStages-1:1], req_valid};
   assign req_stall = !en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= NumStages; k++) begin
            if (en[k]) vld_ff[k] <= vld_in[k];
         end
      end
   end

   // colour rides along
   rgb_type rgb_ff [1:NumStages];
   rgb_type rgb_in [1:NumStages];

   always_comb begin
      rgb_in[1] = '{red: req_red_in, green: req_green_in, blue: req_blue_in};
      for (int k = 2; k <= NumStages; k++) begin
         rgb_in[k] = rgb_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= NumStages; k++) begin
         if (en[k]) rgb_ff[k] <= rgb_in[k];
      end
   end

   // stage 1: raw depth times scale, pixel offsets from the principal point
   logic [39:0]        s1_pd_ff, s1_pd_in;
   logic signed [16:0] s1_dx_ff, s1_dx_in, s1_dy_ff, s1_dy_in;

   assign s1_pd_in = 40'(req_depth_raw) * 40'(depth_scale_ff);
   assign s1_dx_in = $signed({1'b0, req_pixel_col, 4'b0}) - $signed({1'b0, center_x_ff});
   assign s1_dy_in = $signed({1'b0, req_pixel_row, 4'b0}) - $signed({1'b0, center_y_ff});

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_pd_ff <= s1_pd_in;
         s1_dx_ff <= s1_dx_in;
         s1_dy_ff <= s1_dy_in;
      end
   end

   // stage 2: round depth to Q16.16, offsets times reciprocal focal length
   logic [31:0]        s2_d_ff, s2_d_in;
   logic [39:0]        s2_dsum;
   logic signed [41:0] s2_px_full, s2_py_full;
   logic signed [40:0] s2_px_ff, s2_px_in, s2_py_ff, s2_py_in;

   assign s2_dsum    = s1_pd_ff + 40'd128;
   assign s2_d_in    = s2_dsum[39:8];
   assign s2_px_full = s1_dx_ff * $signed({1'b0, inv_focal_x_ff});
   assign s2_py_full = s1_dy_ff * $signed({1'b0, inv_focal_y_ff});
   assign s2_px_in   = s2_px_full[40:0];
   assign s2_py_in   = s2_py_full[40:0];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_d_ff  <= s2_d_in;
         s2_px_ff <= s2_px_in;
         s2_py_ff <= s2_py_in;
      end
   end

   // stage 3: round ray slopes to Q.16
   logic [31:0]        s3_d_ff;
   logic signed [40:0] s3_xsum, s3_ysum;
   logic signed [28:0] s3_rx_ff, s3_rx_in, s3_ry_ff, s3_ry_in;

   assign s3_xsum  = s2_px_ff + 41'sd2048;
   assign s3_ysum  = s2_py_ff + 41'sd2048;
   assign s3_rx_in = s3_xsum[40:12];
   assign s3_ry_in = s3_ysum[40:12];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_d_ff  <= s2_d_ff;
         s3_rx_ff <= s3_rx_in;
         s3_ry_ff <= s3_ry_in;
      end
   end

   // stage 4: ray slope times depth
   logic [31:0]        s4_d_ff;
   logic signed [61:0] s4_mx_full, s4_my_full;
   logic signed [60:0] s4_mx_ff, s4_mx_in, s4_my_ff, s4_my_in;

   assign s4_mx_full = s3_rx_ff * $signed({1'b0, s3_d_ff});
   assign s4_my_full = s3_ry_ff * $signed({1'b0, s3_d_ff});
   assign s4_mx_in   = s4_mx_full[60:0];
   assign s4_my_in   = s4_my_full[60:0];

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_d_ff  <= s3_d_ff;
         s4_mx_ff <= s4_mx_in;
         s4_my_ff <= s4_my_in;
      end
   end

   // stage 5: camera-frame point in Q.16
   logic [31:0]        s5_cz_ff;
   logic signed [60:0] s5_xsum, s5_ysum;
   logic signed [44:0] s5_cx_ff, s5_cx_in, s5_cy_ff, s5_cy_in;

   assign s5_xsum  = s4_mx_ff + 61'sd32768;
   assign s5_ysum  = s4_my_ff + 61'sd32768;
   assign s5_cx_in = s5_xsum[60:16];
   assign s5_cy_in = s5_ysum[60:16];

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_cz_ff <= s4_d_ff;
         s5_cx_ff <= s5_cx_in;
         s5_cy_ff <= s5_cy_in;
      end
   end

   // stage 6: the nine transform products, one row per output coordinate
   logic signed [60:0] s6_pa_ff [3], s6_pa_in [3];
   logic signed [60:0] s6_pb_ff [3], s6_pb_in [3];
   logic signed [48:0] s6_pc_ff [3], s6_pc_in [3];
   logic signed [15:0] s6_t_ff  [3], s6_t_in  [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s6_pa_in[r] = $signed(xform_ff[r][63:48]) * s5_cx_ff;
         s6_pb_in[r] = $signed(xform_ff[r][47:32]) * s5_cy_ff;
         s6_pc_in[r] = $signed(xform_ff[r][31:16]) * $signed({1'b0, s5_cz_ff});
         s6_t_in[r]  = $signed(xform_ff[r][15:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         for (int r = 0; r < 3; r++) begin
            s6_pa_ff[r] <= s6_pa_in[r];
            s6_pb_ff[r] <= s6_pb_in[r];
            s6_pc_ff[r] <= s6_pc_in[r];
            s6_t_ff[r]  <= s6_t_in[r];
         end
      end
   end

   // stage 7: row sums in Q.30, translation lifted from Q7.8
   logic signed [62:0] s7_s_ff [3], s7_s_in [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s7_s_in[r] = 63'(s6_pa_ff[r]) + 63'(s6_pb_ff[r]) + 63'(s6_pc_ff[r])
                    + 63'($signed({s6_t_ff[r], 22'b0}));
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         for (int r = 0; r < 3; r++) s7_s_ff[r] <= s7_s_in[r];
      end
   end

   // stage 8: round to Q.16 and saturate into the output register
   logic signed [62:0] s8_sum [3];
   logic signed [48:0] s8_q   [3];
   logic signed [31:0] s8_pt_ff [3], s8_pt_in [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s8_sum[r] = s7_s_ff[r] + 63'sd8192;
         s8_q[r]   = s8_sum[r][62:14];
         if (s8_q[r][48:31] == '0 || s8_q[r][48:31] == '1) begin
            s8_pt_in[r] = s8_q[r][31:0];
         end else if (s8_q[r][48]) begin
            s8_pt_in[r] = {1'b1, 31'b0};
         end else begin
            s8_pt_in[r] = {1'b0, {31{1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         for (int r = 0; r < 3; r++) s8_pt_ff[r] <= s8_pt_in[r];
      end
   end

   assign rsp_valid     = vld_ff[NumStages];
   assign rsp_point_x   = s8_pt_ff[0];
   assign rsp_point_y   = s8_pt_ff[1];
   assign rsp_point_z   = s8_pt_ff[2];
   assign rsp_blue_out  = rgb_ff[NumStages].blue;
   assign rsp_green_out = rgb_ff[NumStages].green;
   assign rsp_red_out   = rgb_ff[NumStages].red;

endmodule

/* hw/rtl/dpp_checker.sv */
module dpp_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [11:0]        req_pixel_col,
   input  logic [11:0]        req_pixel_row,
   input  logic [15:0]        req_depth_raw,
   input  logic [7:0]         req_blue_in,
   input  logic [7:0]         req_green_in,
   input  logic [7:0]         req_red_in,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_point_x,
   input  logic signed [31:0] rsp_point_y,
   input  logic signed [31:0] rsp_point_z,
   input  logic [7:0]         rsp_blue_out,
   input  logic [7:0]         rsp_green_out,
   input  logic [7:0]         rsp_red_out
);

   logic acc;
   assign acc = req_valid && !req_stall;

   // reset leaves the pipeline empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // a stalled request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_pixel_col)
         && $stable(req_pixel_row) && $stable(req_depth_raw) && $stable(req_blue_in)
         && $stable(req_green_in) && $stable(req_red_in))
      else $error("stalled request beat changed");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point_x) && $stable(rsp_point_y)
         && $stable(rsp_point_z) && $stable(rsp_blue_out) && $stable(rsp_green_out)
         && $stable(rsp_red_out))
      else $error("stalled result beat changed");

   // with no backpressure an accepted beat comes out once it has passed every stage
   a_latency: assert property (@(posedge clock) disable iff (reset)
      acc ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
          ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted beat did not reach rsp after eight cycles");

   // with the output free the pipeline never pushes back
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("req stalled while rsp is free");

endmodule

bind depth_pixel_to_point dpp_checker u_dpp_checker (.*);
